// File: sv/source_tokenizer_assert.svh
// Assertion macros shared by the tokenizer RTL
`ifndef SOURCE_TOKENIZER_ASSERT_SVH
`define SOURCE_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every rising clk edge outside reset
`define STOK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define STOK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define STOK_ASSERT_IMP(lbl, ante, cons, msg)
`define STOK_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/stok_pkg.sv
// Shared types, codes, character classes and lookup tables of the tokenizer
package stok_pkg;

  // default sizes
  localparam int IDENT_PREFIX_LEN_DEF = 8;
  localparam int LINE_WIDTH_DEF       = 16;
  localparam int COL_WIDTH_DEF        = 12;
  localparam int LEN_WIDTH_DEF        = 16;
  localparam int OQ_DEPTH             = 4;
  localparam int KW_MAX_LEN           = 8;
  localparam int KW_COUNT             = 17;

  // token kinds used by name
  localparam logic [5:0] KIND_IDENT = 6'd0;
  localparam logic [5:0] KIND_INT   = 6'd1;
  localparam logic [5:0] KIND_FLOAT = 6'd2;
  localparam logic [5:0] KIND_DIV   = 6'd23;
  localparam logic [5:0] KIND_END   = 6'd51;

  // diagnostic codes
  localparam logic [1:0] DIAG_UNTERM_COMMENT = 2'd0;
  localparam logic [1:0] DIAG_HEX_NO_DIGITS  = 2'd1;
  localparam logic [1:0] DIAG_UNEXPECTED     = 2'd2;
  localparam logic [1:0] DIAG_NONE           = 2'd0;

  localparam logic [7:0] CH_ZERO = 8'h30;

  // keyword table, text right-aligned with the first character highest
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    "fn", "let", "global", "if", "else", "while", "for", "break", "continue",
    "return", "true", "false", "int", "long", "float", "bool", "void"};
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd2, 4'd3, 4'd6, 4'd2, 4'd4, 4'd5, 4'd3, 4'd5, 4'd8,
    4'd6, 4'd4, 4'd5, 4'd3, 4'd4, 4'd5, 4'd4, 4'd4};
  localparam logic [5:0] KW_KIND [KW_COUNT] = '{
    6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19};

  // classified source symbol
  typedef struct packed {
    logic [7:0] b;
    logic       is_end;
    logic       dig;
    logic       alpha;
    logic       under;
    logic       hexd;
    logic       ws;
    logic       nl;
    logic       star;
    logic       slash;
    logic       dot;
    logic       e_chr;
    logic       x_chr;
    logic       sign;
    logic       pair_a;
    logic       single_v;
    logic [5:0] single_k;
  } cls_t;

  // head of the front queue as seen by the lexer
  typedef struct packed {
    logic valid;
    cls_t cls;
  } fq_head_t;

  // single-character operator: {valid, kind}
  function automatic logic [6:0] single_kind(input logic [7:0] b);
    logic [6:0] r;
    r = '0;
    case (b)
      8'h2B: r = {1'b1, 6'd20};
      8'h2D: r = {1'b1, 6'd21};
      8'h2A: r = {1'b1, 6'd22};
      8'h2F: r = {1'b1, 6'd23};
      8'h25: r = {1'b1, 6'd24};
      8'h3D: r = {1'b1, 6'd25};
      8'h3C: r = {1'b1, 6'd28};
      8'h3E: r = {1'b1, 6'd30};
      8'h21: r = {1'b1, 6'd34};
      8'h26: r = {1'b1, 6'd35};
      8'h7C: r = {1'b1, 6'd36};
      8'h5E: r = {1'b1, 6'd37};
      8'h7E: r = {1'b1, 6'd38};
      8'h28: r = {1'b1, 6'd42};
      8'h29: r = {1'b1, 6'd43};
      8'h7B: r = {1'b1, 6'd44};
      8'h7D: r = {1'b1, 6'd45};
      8'h5B: r = {1'b1, 6'd46};
      8'h5D: r = {1'b1, 6'd47};
      8'h2C: r = {1'b1, 6'd48};
      8'h3B: r = {1'b1, 6'd49};
      8'h3A: r = {1'b1, 6'd50};
      default: r = '0;
    endcase
    return r;
  endfunction

  // two-character operator: {valid, kind}
  function automatic logic [6:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
    logic [6:0] r;
    r = '0;
    case ({a, b})
      {8'h26, 8'h26}: r = {1'b1, 6'd32};
      {8'h7C, 8'h7C}: r = {1'b1, 6'd33};
      {8'h3D, 8'h3D}: r = {1'b1, 6'd26};
      {8'h21, 8'h3D}: r = {1'b1, 6'd27};
      {8'h3C, 8'h3D}: r = {1'b1, 6'd29};
      {8'h3E, 8'h3D}: r = {1'b1, 6'd31};
      {8'h3C, 8'h3C}: r = {1'b1, 6'd39};
      {8'h3E, 8'h3E}: r = {1'b1, 6'd40};
      {8'h2D, 8'h3E}: r = {1'b1, 6'd41};
      default: r = '0;
    endcase
    return r;
  endfunction

  // keyword lookup over the first eight identifier bytes (len <= 8)
  function automatic logic [5:0] kw_kind(input logic [63:0] p, input logic [3:0] len);
    logic [6:0]  sh;
    logic [63:0] key;
    logic [5:0]  k;
    sh  = {(4'd8 - len), 3'b000};
    key = p >> sh;
    k   = KIND_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (key == KW_TEXT[i] && len == KW_LEN[i]) k = KW_KIND[i];
    end
    return k;
  endfunction

  // byte classification; the end item carries no byte, so it matches nothing
  function automatic cls_t classify(input logic [7:0] b, input logic is_end);
    cls_t c;
    logic [6:0] s;
    c = '0;
    c.is_end = is_end;
    if (!is_end) begin
      s = single_kind(b);
      c.b     = b;
      c.dig   = b inside {[8'h30:8'h39]};
      c.alpha = b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
      c.under = (b == 8'h5F);
      c.hexd  = b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
      c.ws    = b inside {8'h20, 8'h09, 8'h0D, 8'h0A};
      c.nl    = (b == 8'h0A);
      c.star  = (b == 8'h2A);
      c.slash = (b == 8'h2F);
      c.dot   = (b == 8'h2E);
      c.e_chr = b inside {8'h65, 8'h45};
      c.x_chr = b inside {8'h78, 8'h58};
      c.sign  = b inside {8'h2B, 8'h2D};
      c.pair_a = b inside {8'h26, 8'h7C, 8'h3D, 8'h21, 8'h3C, 8'h3E, 8'h2D};
      c.single_v = s[6];
      c.single_k = s[5:0];
    end
    return c;
  endfunction

endpackage

// File: sv/stok_front.sv
// Front end: accepts source items, classifies them and queues them for the lexer
module stok_front import stok_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_end_marker,
  output fq_head_t   head,
  input  logic       pop
);

  cls_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop_ok;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop_ok   = pop && (cnt_r != 2'd0);

  // queue pointers
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop_ok;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // classified payload
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= classify(in_char_byte, in_end_marker);
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.cls   = q_r[rd_ptr_r];

endmodule

// File: sv/stok_back.sv
// Back end: lexer state machine, lookahead replay and record staging
module stok_back import stok_pkg::*; #(
  parameter int IDENT_PREFIX_LEN = IDENT_PREFIX_LEN_DEF,
  parameter int LINE_WIDTH       = LINE_WIDTH_DEF,
  parameter int COL_WIDTH        = COL_WIDTH_DEF,
  parameter int LEN_WIDTH        = LEN_WIDTH_DEF,
  localparam int REC_W = 1 + 6 + 2 + LINE_WIDTH + COL_WIDTH + LEN_WIDTH + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fq_head_t         head,
  output logic             head_pop,
  input  logic             go,
  output logic             oq_push,
  output logic [REC_W-1:0] oq_data
);

  localparam int IW = $clog2(IDENT_PREFIX_LEN);
  localparam int LW = LINE_WIDTH;
  localparam int CW = COL_WIDTH;
  localparam int NW = LEN_WIDTH;

  typedef enum logic [15:0] {
    M_IDLE   = 16'h0001,
    M_SLASH  = 16'h0002,
    M_LINEC  = 16'h0004,
    M_BLOCKC = 16'h0008,
    M_IDENT  = 16'h0010,
    M_ZERO   = 16'h0020,
    M_HEX0   = 16'h0040,
    M_HEXBAD = 16'h0080,
    M_HEX    = 16'h0100,
    M_DEC    = 16'h0200,
    M_DOT    = 16'h0400,
    M_FRAC   = 16'h0800,
    M_E      = 16'h1000,
    M_ESIGN  = 16'h2000,
    M_EXP    = 16'h4000,
    M_OP     = 16'h8000
  } mode_t;

  typedef enum logic [1:0] {R_DONE, R_AGAIN, R_REPLAY} res_t;

  mode_t          mode_r, mode_nxt;
  cls_t           pend_r [2];
  logic [1:0]     pend_cnt_r, pend_cnt_nxt;
  logic [7:0]     prefix_r [IDENT_PREFIX_LEN];
  logic           overlong_r, overlong_nxt;
  logic           float_r, float_nxt;
  logic           star_r, star_nxt;
  logic [7:0]     opf_r, opf_nxt;
  logic [LW-1:0]  cur_line_r, cur_line_nxt, tok_line_r, tok_line_nxt;
  logic [CW-1:0]  cur_col_r, cur_col_nxt, tok_col_r, tok_col_nxt;
  logic [NW-1:0]  tok_len_r, tok_len_nxt;
  cls_t           rp_r [2];
  logic [1:0]     rp_left_r;
  logic           rp_sel_r;
  logic [REC_W-2:0] hold_r;
  logic           hold_v_r, hold_last_r;

  cls_t           c;
  logic           head_is_rp, step, main_done;
  res_t           res;
  logic           pfx_we, push_p;
  logic [IW-1:0]  pfx_idx;
  logic           rec_v, rec_diag;
  logic [5:0]     rec_kind;
  logic [1:0]     rec_code;
  logic [LW-1:0]  rec_line;
  logic [CW-1:0]  rec_col;
  logic [NW-1:0]  rec_len;
  logic [LW-1:0]  adv_line;
  logic [CW-1:0]  adv_col, pt_col;
  logic [NW-1:0]  len_inc, pt_len;
  logic [CW:0]    pt_col_sum;
  logic [NW:0]    pt_len_sum;
  logic [63:0]    kw_src;
  logic [5:0]     id_kind, num_kind;
  logic [6:0]     pk, sk;
  logic           push_hold, push_last;

  // current symbol: replayed lookahead first, then the queued item
  assign head_is_rp = (rp_left_r != 2'd0);
  assign c          = head_is_rp ? rp_r[rp_sel_r] : head.cls;
  assign step       = go && (head_is_rp || head.valid);
  assign main_done  = step && !head_is_rp && (res == R_DONE);
  assign head_pop   = main_done;

  // position bookkeeping
  always_comb begin
    adv_line = cur_line_r;
    adv_col  = cur_col_r;
    if (c.nl) begin
      if (cur_line_r != '1) adv_line = cur_line_r + 1'b1;
      adv_col = CW'(1);
    end else if (cur_col_r != '1) begin
      adv_col = cur_col_r + 1'b1;
    end
    len_inc    = (tok_len_r == '1) ? tok_len_r : tok_len_r + 1'b1;
    // held lookahead plus this digit: no newline among them
    pt_col_sum = {1'b0, cur_col_r} + (CW+1)'(pend_cnt_r) + (CW+1)'(1);
    pt_len_sum = {1'b0, tok_len_r} + (NW+1)'(pend_cnt_r) + (NW+1)'(1);
    pt_col     = pt_col_sum[CW] ? '1 : pt_col_sum[CW-1:0];
    pt_len     = pt_len_sum[NW] ? '1 : pt_len_sum[NW-1:0];
  end

  // keyword check on the stored identifier prefix
  always_comb begin
    for (int i = 0; i < KW_MAX_LEN; i++) kw_src[63-8*i -: 8] = prefix_r[i];
  end
  assign id_kind  = (!overlong_r && tok_len_r <= NW'(KW_MAX_LEN)) ?
                    kw_kind(kw_src, tok_len_r[3:0]) : KIND_IDENT;
  assign num_kind = float_r ? KIND_FLOAT : KIND_INT;
  assign pk       = pair_kind(opf_r, c.b);
  assign sk       = single_kind(opf_r);

  // lexer step
  always_comb begin
    mode_nxt     = mode_r;
    pend_cnt_nxt = pend_cnt_r;
    overlong_nxt = overlong_r;
    float_nxt    = float_r;
    star_nxt     = star_r;
    opf_nxt      = opf_r;
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    tok_line_nxt = tok_line_r;
    tok_col_nxt  = tok_col_r;
    tok_len_nxt  = tok_len_r;
    res      = R_DONE;
    pfx_we   = 1'b0;
    pfx_idx  = '0;
    push_p   = 1'b0;
    rec_v    = 1'b0;
    rec_diag = 1'b0;
    rec_kind = KIND_IDENT;
    rec_code = DIAG_NONE;
    rec_line = tok_line_r;
    rec_col  = tok_col_r;
    rec_len  = '0;
    case (mode_r)
      M_IDLE: begin
        if (c.is_end) begin
          rec_v = 1'b1; rec_kind = KIND_END;
          rec_line = cur_line_r; rec_col = cur_col_r;
          // new source starts from scratch
          pend_cnt_nxt = '0; overlong_nxt = 1'b0; float_nxt = 1'b0; star_nxt = 1'b0;
          cur_line_nxt = LW'(1); cur_col_nxt = CW'(1);
          tok_line_nxt = LW'(1); tok_col_nxt = CW'(1); tok_len_nxt = '0;
        end else if (c.ws) begin
          cur_line_nxt = adv_line; cur_col_nxt = adv_col;
        end else begin
          tok_line_nxt = cur_line_r; tok_col_nxt = cur_col_r; tok_len_nxt = '0;
          cur_line_nxt = adv_line; cur_col_nxt = adv_col;
          if (c.dig) begin
            float_nxt = 1'b0; pend_cnt_nxt = '0; tok_len_nxt = NW'(1);
            mode_nxt = (c.b == CH_ZERO) ? M_ZERO : M_DEC;
          end else if (c.alpha || c.under) begin
            overlong_nxt = 1'b0; pfx_we = 1'b1; tok_len_nxt = NW'(1);
            mode_nxt = M_IDENT;
          end else if (c.slash) begin
            tok_len_nxt = NW'(1); mode_nxt = M_SLASH;
          end else if (c.pair_a) begin
            opf_nxt = c.b; tok_len_nxt = NW'(1); mode_nxt = M_OP;
          end else if (c.single_v) begin
            tok_len_nxt = NW'(1);
            rec_v = 1'b1; rec_kind = c.single_k;
            rec_line = cur_line_r; rec_col = cur_col_r; rec_len = NW'(1);
          end else begin
            rec_v = 1'b1; rec_diag = 1'b1; rec_code = DIAG_UNEXPECTED;
            rec_line = cur_line_r; rec_col = cur_col_r;
          end
        end
      end
      M_SLASH: begin
        if (c.slash) begin
          cur_line_nxt = adv_line; cur_col_nxt = adv_col; mode_nxt = M_LINEC;
        end else if (c.star) begin
          cur_line_nxt = adv_line; cur_col_nxt = adv_col;
          star_nxt = 1'b0; mode_nxt = M_BLOCKC;
        end else begin
          rec_v = 1'b1; rec_kind = KIND_DIV; rec_len = NW'(1);
          mode_nxt = M_IDLE; res = R_AGAIN;
        end
      end
      M_LINEC: begin
        if (c.is_end || c.nl) begin
          mode_nxt = M_IDLE; res = R_AGAIN;
        end else begin
          cur_line_nxt = adv_line; cur_col_nxt = adv_col;
        end
      end
      M_BLOCKC: begin
        if (c.is_end) begin
          rec_v = 1'b1; rec_diag = 1'b1; rec_code = DIAG_UNTERM_COMMENT;
          mode_nxt = M_IDLE; res = R_AGAIN;
        end else begin
          if (star_r && c.slash) begin
            star_nxt = 1'b0; mode_nxt = M_IDLE;
          end else begin
            star_nxt = c.star;
          end
          cur_line_nxt = adv_line; cur_col_nxt = adv_col;
        end
      end
      M_IDENT: begin
        if (c.alpha || c.dig || c.under) begin
          if (tok_len_r < NW'(IDENT_PREFIX_LEN)) begin
            pfx_we = 1'b1; pfx_idx = tok_len_r[IW-1:0];
          end else begin
            overlong_nxt = 1'b1;
          end
          cur_line_nxt = adv_line; cur_col_nxt = adv_col; tok_len_nxt = len_inc;
        end else begin
          rec_v = 1'b1; rec_kind = id_kind; rec_len = tok_len_r;
          mode_nxt = M_IDLE; res = R_AGAIN;
        end
      end
      M_ZERO: begin
        if (c.x_chr) begin
          cur_line_nxt = adv_line; cur_col_nxt = adv_col; tok_len_nxt = len_inc;
          mode_nxt = M_HEX0;
        end else begin
          mode_nxt = M_DEC; res = R_AGAIN;
        end
      end
      M_HEX0: begin
        if (c.hexd) begin
          cur_line_nxt = adv_line; cur_col_nxt = adv_col; tok_len_nxt = len_inc;
          mode_nxt = M_HEX;
        end else begin
          // diagnostic now, the int token on the next step
          rec_v = 1'b1; rec_diag = 1'b1; rec_code = DIAG_HEX_NO_DIGITS;
          mode_nxt = M_HEXBAD; res = R_AGAIN;
        end
      end
      M_HEXBAD: begin
        rec_v = 1'b1; rec_kind = num_kind; rec_len = tok_len_r;
        mode_nxt = M_IDLE; res = R_AGAIN;
      end
      M_HEX: begin
        if (c.hexd || c.under) begin
          cur_line_nxt = adv_line; cur_col_nxt = adv_col; tok_len_nxt = len_inc;
        end else begin
          rec_v = 1'b1; rec_kind = num_kind; rec_len = tok_len_r;
          mode_nxt = M_IDLE; res = R_AGAIN;
        end
      end
      M_DEC, M_FRAC: begin
        if (c.dig || c.under) begin
          cur_line_nxt = adv_line; cur_col_nxt = adv_col; tok_len_nxt = len_inc;
        end else if (mode_r == M_DEC && c.dot) begin
          push_p = 1'b1; mode_nxt = M_DOT;
        end else if (c.e_chr) begin
          push_p = 1'b1; mode_nxt = M_E;
        end else begin
          rec_v = 1'b1; rec_kind = num_kind; rec_len = tok_len_r;
          mode_nxt = M_IDLE; res = R_AGAIN;
        end
      end
      M_DOT, M_E, M_ESIGN: begin
        if (mode_r == M_E && c.sign) begin
          push_p = 1'b1; mode_nxt = M_ESIGN;
        end else if (c.dig) begin
          // lookahead joins the literal
          cur_col_nxt = pt_col; tok_len_nxt = pt_len; pend_cnt_nxt = '0;
          float_nxt = 1'b1;
          mode_nxt = (mode_r == M_DOT) ? M_FRAC : M_EXP;
        end else begin
          rec_v = 1'b1; rec_kind = num_kind; rec_len = tok_len_r;
          pend_cnt_nxt = '0; mode_nxt = M_IDLE; res = R_REPLAY;
        end
      end
      M_EXP: begin
        if (c.dig) begin
          cur_line_nxt = adv_line; cur_col_nxt = adv_col; tok_len_nxt = len_inc;
        end else begin
          rec_v = 1'b1; rec_kind = num_kind; rec_len = tok_len_r;
          mode_nxt = M_IDLE; res = R_AGAIN;
        end
      end
      M_OP: begin
        if (pk[6]) begin
          cur_line_nxt = adv_line; cur_col_nxt = adv_col; tok_len_nxt = len_inc;
          rec_v = 1'b1; rec_kind = pk[5:0]; rec_len = NW'(2);
          mode_nxt = M_IDLE;
        end else begin
          rec_v = 1'b1; rec_kind = sk[6] ? sk[5:0] : KIND_IDENT; rec_len = NW'(1);
          mode_nxt = M_IDLE; res = R_AGAIN;
        end
      end
      default: begin
        mode_nxt = M_IDLE; res = R_AGAIN;
      end
    endcase
    if (push_p && pend_cnt_r != 2'd2) pend_cnt_nxt = pend_cnt_r + 1'b1;
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      pend_cnt_r <= '0;
      overlong_r <= 1'b0;
      float_r    <= 1'b0;
      star_r     <= 1'b0;
      cur_line_r <= LW'(1);
      cur_col_r  <= CW'(1);
      tok_line_r <= LW'(1);
      tok_col_r  <= CW'(1);
      tok_len_r  <= '0;
      rp_left_r  <= '0;
      rp_sel_r   <= 1'b0;
    end else if (step) begin
      mode_r     <= mode_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      overlong_r <= overlong_nxt;
      float_r    <= float_nxt;
      star_r     <= star_nxt;
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
      tok_line_r <= tok_line_nxt;
      tok_col_r  <= tok_col_nxt;
      tok_len_r  <= tok_len_nxt;
      // replay sequencing
      if (head_is_rp) begin
        if (res == R_DONE) begin
          rp_left_r <= rp_left_r - 1'b1;
          rp_sel_r  <= ~rp_sel_r;
        end
      end else if (res == R_REPLAY) begin
        rp_left_r <= pend_cnt_r;
        rp_sel_r  <= 1'b0;
      end
    end
  end

  // payload storage: lookahead, replay copy, identifier prefix
  always_ff @(posedge clk) begin
    if (step) begin
      opf_r <= opf_nxt;
      if (push_p && pend_cnt_r != 2'd2) pend_r[pend_cnt_r[0]] <= c;
      if (pfx_we) prefix_r[pfx_idx] <= c.b;
      if (!head_is_rp && res == R_REPLAY) begin
        rp_r[0] <= pend_r[0];
        rp_r[1] <= pend_r[1];
      end
    end
  end

  // record staging: one record held back so the last of a run can be marked
  assign push_hold = go && hold_v_r && (hold_last_r || (step && rec_v) || main_done);
  assign push_last = hold_last_r || (main_done && !rec_v);
  assign oq_push   = push_hold;
  assign oq_data   = {hold_r, push_last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      hold_last_r <= 1'b0;
    end else if (step && rec_v) begin
      hold_v_r    <= 1'b1;
      hold_last_r <= main_done;
    end else if (push_hold) begin
      hold_v_r    <= 1'b0;
      hold_last_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && rec_v) begin
      hold_r <= {rec_diag, rec_kind, rec_code, rec_line, rec_col, rec_len};
    end
  end

endmodule

// File: sv/stok_outq.sv
// Output record queue absorbing bursts of several records per input
module stok_outq import stok_pkg::*; #(
  parameter int W     = 54,
  parameter int DEPTH = OQ_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [W-1:0] dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [W-1:0]   mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full      = (cnt_r == CNW'(DEPTH));
  assign out_valid = (cnt_r != '0);
  assign dout      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = out_valid && !out_stall;

  // pointer wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    cnt_nxt = cnt_r + CNW'(do_push) - CNW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

endmodule

// File: sv/source_tokenizer.sv
// Top level of the streaming source tokenizer
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall   char_byte, end_marker
//  out_     output     out_valid/out_stall is_diagnostic, token_kind, diag_code,
//                                          start_line, start_col, tok_length, last_of_run
//
// One lexer step per cycle while the record queue is not full and a symbol waits.
// A skipped or extending byte is consumed; a byte that ends a token is lexed again
// after the token record, after a lone 0 via the decimal state and after a hex
// prefix with no digits after its diagnostic and int token; a number that gives
// back lookahead replays the held bytes first. Records pass a staging register.
// Reset (rst_n low, synchronous) empties both queues; ready the cycle after. A stall
// on out_ fills the four-entry record queue, the lexer, then the front queue and in_stall.
`include "source_tokenizer_assert.svh"
module source_tokenizer import stok_pkg::*; #(
  parameter int IDENT_PREFIX_LEN = IDENT_PREFIX_LEN_DEF,
  parameter int LINE_WIDTH       = LINE_WIDTH_DEF,
  parameter int COL_WIDTH        = COL_WIDTH_DEF,
  parameter int LEN_WIDTH        = LEN_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_char_byte,
  input  logic                  in_end_marker,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_is_diagnostic,
  output logic [5:0]            out_token_kind,
  output logic [1:0]            out_diag_code,
  output logic [LINE_WIDTH-1:0] out_start_line,
  output logic [COL_WIDTH-1:0]  out_start_col,
  output logic [LEN_WIDTH-1:0]  out_tok_length,
  output logic                  out_last_of_run
);

  localparam int REC_W = 1 + 6 + 2 + LINE_WIDTH + COL_WIDTH + LEN_WIDTH + 1;

  fq_head_t         fq_head;
  logic             fq_pop;
  logic             oq_full, oq_push;
  logic [REC_W-1:0] oq_din, oq_dout;

  // classify and queue
  stok_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_byte  (in_char_byte),
    .in_end_marker (in_end_marker),
    .head          (fq_head),
    .pop           (fq_pop)
  );

  // lexer
  stok_back #(
    .IDENT_PREFIX_LEN (IDENT_PREFIX_LEN),
    .LINE_WIDTH       (LINE_WIDTH),
    .COL_WIDTH        (COL_WIDTH),
    .LEN_WIDTH        (LEN_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (fq_head),
    .head_pop (fq_pop),
    .go       (!oq_full),
    .oq_push  (oq_push),
    .oq_data  (oq_din)
  );

  // record queue
  stok_outq #(
    .W     (REC_W),
    .DEPTH (OQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (oq_push),
    .din       (oq_din),
    .full      (oq_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (oq_dout)
  );

  assign {out_is_diagnostic, out_token_kind, out_diag_code, out_start_line,
          out_start_col, out_tok_length, out_last_of_run} = oq_dout;

  // checks
  `STOK_ASSERT_IMP(a_diag_fields, out_valid && out_is_diagnostic, out_token_kind == KIND_IDENT && out_tok_length == '0, "diagnostic record carries token fields")
  `STOK_ASSERT_IMP(a_end_last, out_valid && !out_is_diagnostic && out_token_kind == KIND_END, out_last_of_run, "end token not last of its run")
  `STOK_ASSERT_IMP(a_no_overflow, oq_full, !oq_push, "record pushed into full queue")
  `STOK_ASSERT_NXT(a_fq_hold, in_stall && !fq_pop, in_stall, "front queue lost an entry without a pop")

endmodule

// File: test/source_tokenizer_checker.sv
// Checker for the source tokenizer: predicts token and diagnostic records and compares them
`timescale 1ns / 1ps
module source_tokenizer_checker import stok_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_marker,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_is_diagnostic,
  input  logic [5:0]  out_token_kind,
  input  logic [1:0]  out_diag_code,
  input  logic [15:0] out_start_line,
  input  logic [11:0] out_start_col,
  input  logic [15:0] out_tok_length,
  input  logic        out_last_of_run,
  output int          fail_count,
  output int          records_waiting
);

  localparam int END_SYM  = 256;
  localparam int LINE_MAX = 65535;
  localparam int COL_MAX  = 4095;
  localparam int LEN_MAX  = 65535;
  localparam int PREFIX_N = 8;
  localparam int MAX_RECS = 6;

  typedef enum int {
    LX_IDLE, LX_SLASH, LX_LINEC, LX_BLOCKC, LX_IDENT, LX_ZERO, LX_HEX0, LX_HEX,
    LX_DEC, LX_DOT, LX_FRAC, LX_E, LX_ESIGN, LX_EXP, LX_OP
  } lex_state_t;

  typedef enum int {STEP_DONE, STEP_AGAIN, STEP_REPLAY} step_t;

  typedef struct {
    logic        diag;
    logic [5:0]  kind;
    logic [1:0]  code;
    logic [15:0] line;
    logic [11:0] col;
    logic [15:0] len;
    logic        last;
  } token_rec_t;

  // keyword spellings, kinds 3..19 in this order
  string keywords [17] = '{"fn", "let", "global", "if", "else", "while", "for", "break",
    "continue", "return", "true", "false", "int", "long", "float", "bool", "void"};
  string single_ops = "+-*/%=<>!&|^~(){}[],;:";
  int single_kinds [22] = '{20, 21, 22, 23, 24, 25, 28, 30, 34, 35, 36,
                            37, 38, 42, 43, 44, 45, 46, 47, 48, 49, 50};
  string pair_a = "&|=!<><>-";
  string pair_b = "&|====<>>";
  int pair_kinds [9] = '{32, 33, 26, 27, 29, 31, 39, 40, 41};

  lex_state_t mode;
  logic [7:0] held_bytes [2];
  int         held_n;
  logic [7:0] prefix [PREFIX_N];
  bit         overlong, saw_float, saw_star;
  logic [7:0] op_first;
  int         cur_line, cur_col, tok_line, tok_col, tok_len;

  token_rec_t step_recs [$];
  token_rec_t expected_recs [$];

  function automatic void clear_lexer();
    mode = LX_IDLE;
    held_n = 0;
    held_bytes[0] = 0;
    held_bytes[1] = 0;
    overlong = 0;
    saw_float = 0;
    saw_star = 0;
    op_first = 0;
    cur_line = 1; cur_col = 1; tok_line = 1; tok_col = 1; tok_len = 0;
  endfunction

  function automatic bit is_digit(int c); return c >= "0" && c <= "9"; endfunction
  function automatic bit is_alpha(int c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit is_hex(int c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic int single_op_kind(int c);
    for (int i = 0; i < 22; i++) if (single_ops[i] == c) return single_kinds[i];
    return -1;
  endfunction

  function automatic int pair_op_kind(int a, int b);
    for (int i = 0; i < 9; i++) if (pair_a[i] == a && pair_b[i] == b) return pair_kinds[i];
    return -1;
  endfunction

  function automatic bit starts_pair(int c);
    for (int i = 0; i < 9; i++) if (pair_a[i] == c) return 1;
    return 0;
  endfunction

  function automatic void add_rec(bit d, int k, int code, int ln, int cl, int n);
    token_rec_t r;
    if (step_recs.size() >= MAX_RECS) return;
    r.diag = d; r.kind = 6'(k); r.code = 2'(code); r.line = 16'(ln); r.col = 12'(cl);
    r.len = 16'(n); r.last = 0;
    step_recs.insert(step_recs.size(), r);
  endfunction

  // position and length bookkeeping
  function automatic void advance(int c);
    if (c == 8'h0A) begin
      if (cur_line < LINE_MAX) cur_line++;
      cur_col = 1;
    end else if (cur_col < COL_MAX) begin
      cur_col++;
    end
  endfunction

  function automatic void absorb(int c);
    advance(c);
    if (tok_len < LEN_MAX) tok_len++;
  endfunction

  function automatic void absorb_held();
    for (int k = 0; k < held_n && k < 2; k++) absorb(held_bytes[k]);
    held_n = 0;
  endfunction

  function automatic void hold(int c);
    if (held_n < 2) begin
      held_bytes[held_n] = 8'(c);
      held_n++;
    end
  endfunction

  function automatic void close_number();
    add_rec(0, saw_float ? KIND_FLOAT : KIND_INT, DIAG_NONE, tok_line, tok_col, tok_len);
    mode = LX_IDLE;
  endfunction

  function automatic void close_ident();
    int k;
    bit hit;
    k = KIND_IDENT;
    if (!overlong && tok_len <= PREFIX_N) begin
      for (int i = 0; i < 17; i++) begin
        if (keywords[i].len() == tok_len) begin
          hit = 1;
          for (int j = 0; j < tok_len; j++) if (prefix[j] != keywords[i][j]) hit = 0;
          if (hit) k = 3 + i;
        end
      end
    end
    add_rec(0, k, DIAG_NONE, tok_line, tok_col, tok_len);
    mode = LX_IDLE;
  endfunction

  // one lexer decision on one symbol
  function automatic step_t lex_symbol(int c);
    int k;
    case (mode)
      LX_IDLE: begin
        if (c == END_SYM) begin
          add_rec(0, KIND_END, DIAG_NONE, cur_line, cur_col, 0);
          clear_lexer();
          return STEP_DONE;
        end
        if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
          advance(c);
          return STEP_DONE;
        end
        tok_line = cur_line; tok_col = cur_col; tok_len = 0;
        if (is_digit(c)) begin
          saw_float = 0; held_n = 0; absorb(c);
          mode = (c == "0") ? LX_ZERO : LX_DEC;
          return STEP_DONE;
        end
        if (is_alpha(c) || c == "_") begin
          overlong = 0; prefix[0] = 8'(c); absorb(c);
          mode = LX_IDENT;
          return STEP_DONE;
        end
        if (c == "/") begin
          absorb(c); mode = LX_SLASH;
          return STEP_DONE;
        end
        if (starts_pair(c)) begin
          op_first = 8'(c); absorb(c); mode = LX_OP;
          return STEP_DONE;
        end
        k = single_op_kind(c);
        if (k >= 0) begin
          absorb(c);
          add_rec(0, k, DIAG_NONE, tok_line, tok_col, 1);
          return STEP_DONE;
        end
        add_rec(1, 0, DIAG_UNEXPECTED, cur_line, cur_col, 0);
        advance(c);
        return STEP_DONE;
      end
      LX_SLASH: begin
        if (c == "/") begin advance(c); mode = LX_LINEC; return STEP_DONE; end
        if (c == "*") begin advance(c); saw_star = 0; mode = LX_BLOCKC; return STEP_DONE; end
        add_rec(0, KIND_DIV, DIAG_NONE, tok_line, tok_col, 1);
        mode = LX_IDLE;
        return STEP_AGAIN;
      end
      LX_LINEC: begin
        if (c == END_SYM || c == 8'h0A) begin mode = LX_IDLE; return STEP_AGAIN; end
        advance(c);
        return STEP_DONE;
      end
      LX_BLOCKC: begin
        if (c == END_SYM) begin
          add_rec(1, 0, DIAG_UNTERM_COMMENT, tok_line, tok_col, 0);
          mode = LX_IDLE;
          return STEP_AGAIN;
        end
        if (saw_star && c == "/") begin
          saw_star = 0; mode = LX_IDLE;
        end else begin
          saw_star = (c == "*");
        end
        advance(c);
        return STEP_DONE;
      end
      LX_IDENT: begin
        if (c != END_SYM && (is_alpha(c) || is_digit(c) || c == "_")) begin
          if (tok_len < PREFIX_N) prefix[tok_len] = 8'(c);
          else overlong = 1;
          absorb(c);
          return STEP_DONE;
        end
        close_ident();
        return STEP_AGAIN;
      end
      LX_ZERO: begin
        if (c == "x" || c == "X") begin absorb(c); mode = LX_HEX0; return STEP_DONE; end
        mode = LX_DEC;
        return STEP_AGAIN;
      end
      LX_HEX0: begin
        if (c != END_SYM && is_hex(c)) begin absorb(c); mode = LX_HEX; return STEP_DONE; end
        add_rec(1, 0, DIAG_HEX_NO_DIGITS, tok_line, tok_col, 0);
        close_number();
        return STEP_AGAIN;
      end
      LX_HEX: begin
        if (c != END_SYM && (is_hex(c) || c == "_")) begin absorb(c); return STEP_DONE; end
        close_number();
        return STEP_AGAIN;
      end
      LX_DEC, LX_FRAC: begin
        if (is_digit(c) || c == "_") begin absorb(c); return STEP_DONE; end
        if (mode == LX_DEC && c == ".") begin hold(c); mode = LX_DOT; return STEP_DONE; end
        if (c == "e" || c == "E") begin hold(c); mode = LX_E; return STEP_DONE; end
        close_number();
        return STEP_AGAIN;
      end
      LX_DOT: begin
        if (is_digit(c)) begin
          absorb_held(); absorb(c); saw_float = 1; mode = LX_FRAC;
          return STEP_DONE;
        end
        close_number();
        return STEP_REPLAY;
      end
      LX_E, LX_ESIGN: begin
        if (mode == LX_E && (c == "+" || c == "-")) begin
          hold(c); mode = LX_ESIGN;
          return STEP_DONE;
        end
        if (is_digit(c)) begin
          absorb_held(); absorb(c); saw_float = 1; mode = LX_EXP;
          return STEP_DONE;
        end
        close_number();
        return STEP_REPLAY;
      end
      LX_EXP: begin
        if (is_digit(c)) begin absorb(c); return STEP_DONE; end
        close_number();
        return STEP_AGAIN;
      end
      LX_OP: begin
        k = (c == END_SYM) ? -1 : pair_op_kind(op_first, c);
        if (k >= 0) begin
          absorb(c);
          add_rec(0, k, DIAG_NONE, tok_line, tok_col, 2);
          mode = LX_IDLE;
          return STEP_DONE;
        end
        k = single_op_kind(op_first);
        add_rec(0, k < 0 ? 0 : k, DIAG_NONE, tok_line, tok_col, 1);
        mode = LX_IDLE;
        return STEP_AGAIN;
      end
      default: begin
        mode = LX_IDLE;
        return STEP_AGAIN;
      end
    endcase
  endfunction

  // feed a symbol, lexing again on give-back and replaying held lookahead
  function automatic void feed_symbol(int c, int depth);
    step_t r;
    logic [7:0] back [2];
    int n;
    for (int g = 0; g < 16; g++) begin
      r = lex_symbol(c);
      if (r == STEP_DONE) return;
      if (r == STEP_REPLAY) begin
        n = held_n > 2 ? 2 : held_n;
        back = held_bytes;
        held_n = 0;
        if (depth < 2) for (int k = 0; k < n; k++) feed_symbol(back[k], depth + 1);
      end
    end
  endfunction

  // predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    token_rec_t e;
    if (!rst_n) begin
      clear_lexer();
      step_recs.delete();
      expected_recs.delete();
      fail_count <= 0;
      records_waiting <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        step_recs.delete();
        feed_symbol(in_end_marker ? END_SYM : int'(in_char_byte), 0);
        if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1;
        expected_recs = {expected_recs, step_recs};
      end
      if (out_valid && !out_stall) begin
        if (expected_recs.size() == 0) begin
          $display("%0t: unexpected record diag=%0d kind=%0d code=%0d line=%0d col=%0d len=%0d",
                   $time, out_is_diagnostic, out_token_kind, out_diag_code, out_start_line,
                   out_start_col, out_tok_length);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_recs.pop_front();
          if (e.diag !== out_is_diagnostic || e.kind !== out_token_kind
              || e.code !== out_diag_code || e.line !== out_start_line
              || e.col !== out_start_col || e.len !== out_tok_length
              || e.last !== out_last_of_run) begin
            $display("%0t: mismatch expected diag=%0d kind=%0d code=%0d line=%0d col=%0d len=%0d last=%0d",
                     $time, e.diag, e.kind, e.code, e.line, e.col, e.len, e.last);
            $display("%0t:          actual   diag=%0d kind=%0d code=%0d line=%0d col=%0d len=%0d last=%0d",
                     $time, out_is_diagnostic, out_token_kind, out_diag_code, out_start_line,
                     out_start_col, out_tok_length, out_last_of_run);
            fail_count <= fail_count + 1;
          end
        end
      end
      records_waiting <= expected_recs.size();
    end
  end

endmodule

// File: test/source_tokenizer_tb.sv
// Testbench top for the source tokenizer: byte stimulus, flow control and verdict
`timescale 1ns / 1ps
module source_tokenizer_tb;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_byte;
  logic        in_end_marker;
  logic        out_valid;
  logic        out_stall;
  logic        out_is_diagnostic;
  logic [5:0]  out_token_kind;
  logic [1:0]  out_diag_code;
  logic [15:0] out_start_line;
  logic [11:0] out_start_col;
  logic [15:0] out_tok_length;
  logic        out_last_of_run;
  int          fail_count;
  int          records_waiting;
  int          src_idle_pct;
  int          rcv_stall_pct;
  int          bytes_sent;

  string keywords [17] = '{"fn", "let", "global", "if", "else", "while", "for", "break",
    "continue", "return", "true", "false", "int", "long", "float", "bool", "void"};
  string operators [31] = '{"+", "-", "*", "/", "%", "=", "==", "!=", "<", "<=", ">", ">=",
    "&&", "||", "!", "&", "|", "^", "~", "<<", ">>", "->", "(", ")", "{", "}", "[", "]",
    ",", ";", ":"};
  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  string hex_chars  = "0123456789abcdefABCDEF_";
  string ws_chars   = " \t\r\n";

  source_tokenizer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_char_byte(in_char_byte), .in_end_marker(in_end_marker),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_is_diagnostic(out_is_diagnostic), .out_token_kind(out_token_kind),
    .out_diag_code(out_diag_code), .out_start_line(out_start_line),
    .out_start_col(out_start_col), .out_tok_length(out_tok_length),
    .out_last_of_run(out_last_of_run)
  );

  source_tokenizer_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_char_byte(in_char_byte), .in_end_marker(in_end_marker),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_is_diagnostic(out_is_diagnostic), .out_token_kind(out_token_kind),
    .out_diag_code(out_diag_code), .out_start_line(out_start_line),
    .out_start_col(out_start_col), .out_tok_length(out_tok_length),
    .out_last_of_run(out_last_of_run),
    .fail_count(fail_count), .records_waiting(records_waiting)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #30ms;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver flow control
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
  end

  // one transfer on the input channel; called at a falling edge
  task automatic send_byte(input logic [7:0] b, input bit fin);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_char_byte = b;
    in_end_marker = fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 0;
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 0);
  endtask

  task automatic close_source();
    send_byte(8'($urandom_range(0, 255)), 1);
  endtask

  task automatic drain();
    while (records_waiting != 0) @(negedge clk);
  endtask

  function automatic string pick_from(string set, int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(set[$urandom_range(0, set.len() - 1)])};
    return s;
  endfunction

  function automatic string digits(int n);
    return pick_from("0123456789", n);
  endfunction

  // mostly well-formed lexemes with random content
  function automatic string random_lexeme();
    string s;
    case ($urandom_range(0, 8))
      0: s = keywords[$urandom_range(0, 16)];
      1: s = {pick_from("abcXYZ_q", 1), pick_from(word_chars, $urandom_range(0, 11))};
      2: s = {digits(1), pick_from("0123456789_", $urandom_range(0, 5))};
      3: s = {"0", pick_from("xX", 1), pick_from(hex_chars, $urandom_range(0, 5))};
      4: begin
        s = digits($urandom_range(1, 3));
        if ($urandom_range(0, 1)) s = {s, ".", digits($urandom_range(0, 2))};
        if ($urandom_range(0, 1)) s = {s, pick_from("eE", 1), pick_from("+-5", 1),
                                       digits($urandom_range(0, 2))};
      end
      5: s = operators[$urandom_range(0, 30)];
      6: s = pick_from(ws_chars, $urandom_range(1, 3));
      7: s = {"//", pick_from(word_chars, $urandom_range(0, 6)), "\n"};
      default: s = {"/*", pick_from("a*/ \n*", $urandom_range(0, 6)), "*/"};
    endcase
    return s;
  endfunction

  task automatic random_phase(input int count);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      case ($urandom_range(0, 19))
        0: send_byte(8'($urandom_range(0, 255)), 0);
        1: close_source();
        default: begin
          send_text(random_lexeme());
          if ($urandom_range(0, 2) == 0) send_text(pick_from(ws_chars, 1));
        end
      endcase
    end
    close_source();
  endtask

  initial begin
    int guard;
    rst_n = 0;
    in_valid = 0;
    in_char_byte = 0;
    in_end_marker = 0;
    src_idle_pct = 20;
    rcv_stall_pct = 52;
    bytes_sent = 0;
    repeat (10) @(negedge clk);
    rst_n = 1;

    // directed: keywords, operators, numbers with lookahead, comments, bad bytes
    send_text("fn continue x_9 1_0 0x1F 0x; 1.5e+3 7. 2e 3e- ");
    send_text("a<<=b->c!=d&&|| // note\n/* x **/ ");
    send_byte(8'h00, 0);
    send_byte(8'hFF, 0);
    send_byte(8'h80, 0);
    send_text(". @ 4.e5 0x");
    close_source();
    send_text("/* never closed");
    close_source();
    send_text("1e");
    close_source();
    drain();

    random_phase(110);
    drain();
    src_idle_pct = 52;
    rcv_stall_pct = 20;
    random_phase(110);
    drain();
    src_idle_pct = 0;
    rcv_stall_pct = 0;
    random_phase(120);

    // wait for outstanding records, then let the pipeline settle
    guard = 0;
    while (records_waiting != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
    if (fail_count == 0 && records_waiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/stok_pkg.sv
sv/stok_front.sv
sv/stok_back.sv
sv/stok_outq.sv
sv/source_tokenizer.sv
test/source_tokenizer_checker.sv
test/source_tokenizer_tb.sv
